### src/absd_pkg.sv
// Types and constants shared by the ADC block average and seat detect block.
// No dependencies; every other file uses this package by scoped names.
package absd_pkg;

  localparam int SAMPLE_W  = 12;
  localparam int SUM_W     = 15;
  localparam int HOLD_W    = 10;
  localparam int IDX_W     = 3;
  localparam int NUM_CH    = 7;
  localparam int NUM_SEATS = 4;
  localparam int CFG_IDX_W = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_SEAT_THRESHOLD = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_RELOAD    = 4'd1;

  localparam logic [SAMPLE_W-1:0] SEAT_THRESHOLD_RST = 12'd1000;
  localparam logic [HOLD_W-1:0]   HOLD_RELOAD_RST    = 10'd1000;

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic [SUM_W-1:0]    sum_t;
  typedef logic [HOLD_W-1:0]   hold_t;

  typedef sample_t [NUM_CH-1:0] scan_t;
  typedef sum_t    [NUM_CH-1:0] sums_t;

  typedef struct packed {
    logic  vld;
    sums_t sums;
  } blk_t;

  typedef struct packed {
    sample_t seat_threshold;
    hold_t   hold_reload;
  } cfg_t;

  typedef struct packed {
    scan_t                avg;
    logic [NUM_SEATS-1:0] mask;
    logic [2:0]           count;
  } res_t;

endpackage

### src/absd_scan_if.sv
// Input channel: one ADC scan of seven 12-bit samples per word.
// Depends on absd_pkg for the sample type.
interface absd_scan_if;
  logic                valid;
  logic                ready;
  absd_pkg::sample_t   seat1_sample;
  absd_pkg::sample_t   seat2_sample;
  absd_pkg::sample_t   seat3_sample;
  absd_pkg::sample_t   seat4_sample;
  absd_pkg::sample_t   height1_sample;
  absd_pkg::sample_t   height2_sample;
  absd_pkg::sample_t   height3_sample;

  modport source (
    output valid, seat1_sample, seat2_sample, seat3_sample, seat4_sample,
           height1_sample, height2_sample, height3_sample,
    input  ready
  );
  modport sink (
    input  valid, seat1_sample, seat2_sample, seat3_sample, seat4_sample,
           height1_sample, height2_sample, height3_sample,
    output ready
  );
endinterface

### src/absd_result_if.sv
// Output channel: block averages plus seat occupancy mask and count per word.
// Depends on absd_pkg for field types.
interface absd_result_if;
  logic                               valid;
  logic                               ready;
  absd_pkg::sample_t                  seat1_avg;
  absd_pkg::sample_t                  seat2_avg;
  absd_pkg::sample_t                  seat3_avg;
  absd_pkg::sample_t                  seat4_avg;
  absd_pkg::sample_t                  height1_avg;
  absd_pkg::sample_t                  height2_avg;
  absd_pkg::sample_t                  height3_avg;
  logic [absd_pkg::NUM_SEATS-1:0]     occupied_mask;
  logic [2:0]                         occupied_count;

  modport source (
    output valid, seat1_avg, seat2_avg, seat3_avg, seat4_avg,
           height1_avg, height2_avg, height3_avg, occupied_mask, occupied_count,
    input  ready
  );
  modport sink (
    input  valid, seat1_avg, seat2_avg, seat3_avg, seat4_avg,
           height1_avg, height2_avg, height3_avg, occupied_mask, occupied_count,
    output ready
  );
endinterface

### src/absd_cfg_if.sv
// Configuration write channel: register index and write data per word.
// Depends on absd_pkg for widths.
interface absd_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [absd_pkg::CFG_IDX_W-1:0]     index;
  logic [absd_pkg::SAMPLE_W-1:0]      data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### src/absd_accum.sv
// Scan input register and per-channel block sums with scan index.
// Depends on absd_pkg; hands a finished block of sums to absd_detect.
module absd_accum #(
  parameter int SCANS_PER_BLOCK = 5
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            adv,
  input  logic            in_vld,
  input  absd_pkg::scan_t in_scan,
  output absd_pkg::blk_t  blk
);

  localparam int IW = absd_pkg::IDX_W + 1;
  localparam logic [IW-1:0] BLK_LEN = IW'(SCANS_PER_BLOCK);

  logic                         scan_vld;
  absd_pkg::scan_t              scan_q;
  absd_pkg::sums_t              sums;
  absd_pkg::sums_t              sums_tot;
  logic [absd_pkg::IDX_W-1:0]   scan_index;
  logic                         last;

  always_comb begin
    for (int c = 0; c < absd_pkg::NUM_CH; c++) begin
      sums_tot[c] = sums[c] + absd_pkg::sum_t'(scan_q[c]);
    end
    last = (IW'({1'b0, scan_index}) + IW'(1)) >= BLK_LEN;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_vld   <= 1'b0;
      blk.vld    <= 1'b0;
      scan_index <= '0;
      sums       <= '0;
    end else if (adv) begin
      scan_vld <= in_vld;
      scan_q   <= in_scan;
      blk.vld  <= scan_vld && last;
      if (scan_vld) begin
        if (last) begin
          blk.sums   <= sums_tot;
          sums       <= '0;
          scan_index <= '0;
        end else begin
          sums       <= sums_tot;
          scan_index <= scan_index + 1'b1;
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_index_in_block: assert property (@(posedge clk) disable iff (rst)
    IW'({1'b0, scan_index}) < BLK_LEN)
    else $error("scan index beyond block");

  a_block_restarts: assert property (@(posedge clk) disable iff (rst)
    blk.vld |-> (scan_index == '0))
    else $error("block emitted without index restart");
`endif

endmodule

### src/absd_detect.sv
// Block average by reciprocal multiply, seat hold counters and result register.
// Depends on absd_pkg; fed by absd_accum.
module absd_detect #(
  parameter int SCANS_PER_BLOCK = 5
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            adv,
  input  absd_pkg::blk_t  blk,
  input  absd_pkg::cfg_t  cfg,
  output logic            out_vld,
  output absd_pkg::res_t  res
);

  localparam int DIV_SHIFT = 18;
  localparam int MUL_W     = 19;
  localparam int PW        = absd_pkg::SUM_W + MUL_W;
  localparam logic [MUL_W-1:0] DIV_MUL =
    MUL_W'((2 ** DIV_SHIFT + SCANS_PER_BLOCK - 1) / SCANS_PER_BLOCK);

  logic [PW-1:0]                         prod [absd_pkg::NUM_CH];
  absd_pkg::scan_t                       avg;
  absd_pkg::hold_t                       hold      [absd_pkg::NUM_SEATS];
  absd_pkg::hold_t                       hold_next [absd_pkg::NUM_SEATS];
  logic [absd_pkg::NUM_SEATS-1:0]        mask_next;
  logic [2:0]                            count_next;

  always_comb begin
    for (int c = 0; c < absd_pkg::NUM_CH; c++) begin
      prod[c] = PW'(blk.sums[c]) * PW'(DIV_MUL);
      avg[c]  = prod[c][DIV_SHIFT +: absd_pkg::SAMPLE_W];
    end
    count_next = '0;
    for (int s = 0; s < absd_pkg::NUM_SEATS; s++) begin
      if (avg[s] < cfg.seat_threshold) begin
        hold_next[s] = cfg.hold_reload;
      end else if (hold[s] != '0) begin
        hold_next[s] = hold[s] - 1'b1;
      end else begin
        hold_next[s] = hold[s];
      end
      mask_next[s] = hold_next[s] != '0;
      count_next   = count_next + 3'(mask_next[s]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
      for (int s = 0; s < absd_pkg::NUM_SEATS; s++) begin
        hold[s] <= '0;
      end
    end else if (adv) begin
      out_vld <= blk.vld;
      if (blk.vld) begin
        for (int s = 0; s < absd_pkg::NUM_SEATS; s++) begin
          hold[s] <= hold_next[s];
        end
        res.avg   <= avg;
        res.mask  <= mask_next;
        res.count <= count_next;
      end
    end
  end

`ifndef SYNTHESIS
  a_mask_matches_hold: assert property (@(posedge clk) disable iff (rst)
    out_vld |-> (res.mask[0] == (hold[0] != '0)) && (res.mask[1] == (hold[1] != '0)) &&
                (res.mask[2] == (hold[2] != '0)) && (res.mask[3] == (hold[3] != '0)))
    else $error("occupied mask out of step with hold counters");

  a_zero_reload_clears: assert property (@(posedge clk) disable iff (rst)
    (adv && blk.vld && cfg.hold_reload == '0 && avg[0] < cfg.seat_threshold)
      |=> (hold[0] == '0))
    else $error("zero reload left seat one held");
`endif

endmodule

### src/adc_block_average_seat_detect.sv
// A result word passes the input register, sum register and result register, in
// that order, after the edge that takes the last scan of a block.
// Throughput: one scan word per cycle while not stalled; one result word per SCANS_PER_BLOCK scans.
// All stages advance together while the result register is empty or taken.
// Reset (synchronous): clears sums, scan index, hold counters and valids;
// seat_threshold and hold_reload return to 1000.
module adc_block_average_seat_detect #(
  parameter int SCANS_PER_BLOCK = 5
) (
  input  logic                 clk,
  input  logic                 rst,
  absd_scan_if.sink            scan,
  absd_result_if.source        result,
  absd_cfg_if.sink             cfg
);

  logic             adv;
  logic             out_vld;
  absd_pkg::scan_t  in_scan;
  absd_pkg::blk_t   blk;
  absd_pkg::cfg_t   cfg_q;
  absd_pkg::res_t   res;

  assign adv        = !out_vld || result.ready;
  assign scan.ready = adv;
  assign cfg.ready  = 1'b1;

  assign in_scan[0] = scan.seat1_sample;
  assign in_scan[1] = scan.seat2_sample;
  assign in_scan[2] = scan.seat3_sample;
  assign in_scan[3] = scan.seat4_sample;
  assign in_scan[4] = scan.height1_sample;
  assign in_scan[5] = scan.height2_sample;
  assign in_scan[6] = scan.height3_sample;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_q.seat_threshold <= absd_pkg::SEAT_THRESHOLD_RST;
      cfg_q.hold_reload    <= absd_pkg::HOLD_RELOAD_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        absd_pkg::CFG_SEAT_THRESHOLD: cfg_q.seat_threshold <= cfg.data;
        absd_pkg::CFG_HOLD_RELOAD:    cfg_q.hold_reload <= cfg.data[absd_pkg::HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  absd_accum #(
    .SCANS_PER_BLOCK (SCANS_PER_BLOCK)
  ) u_accum (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .in_vld  (scan.valid),
    .in_scan (in_scan),
    .blk     (blk)
  );

  absd_detect #(
    .SCANS_PER_BLOCK (SCANS_PER_BLOCK)
  ) u_detect (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .blk     (blk),
    .cfg     (cfg_q),
    .out_vld (out_vld),
    .res     (res)
  );

  assign result.valid          = out_vld;
  assign result.seat1_avg      = res.avg[0];
  assign result.seat2_avg      = res.avg[1];
  assign result.seat3_avg      = res.avg[2];
  assign result.seat4_avg      = res.avg[3];
  assign result.height1_avg    = res.avg[4];
  assign result.height2_avg    = res.avg[5];
  assign result.height3_avg    = res.avg[6];
  assign result.occupied_mask  = res.mask;
  assign result.occupied_count = res.count;

`ifndef SYNTHESIS
  a_count_matches_mask: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.occupied_count == 3'($countones(result.occupied_mask))))
    else $error("occupied count disagrees with mask");

  a_no_accept_while_blocked: assert property (@(posedge clk) disable iff (rst)
    (out_vld && !result.ready) |-> !scan.ready)
    else $error("scan taken while result word is blocked");
`endif

endmodule
